[rtl/bounded_ring_deque_macros.svh]
// Assertion macros used by the checker file of the bounded ring deque.
`ifndef BOUNDED_RING_DEQUE_MACROS_SVH
`define BOUNDED_RING_DEQUE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define BRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A beat that is offered and not taken is still offered in the next cycle.
`define BRD_ASSERT_HOLD(name, vld, rdy, msg) \
  `BRD_ASSERT(name, vld && !rdy |=> vld, msg)

`endif

[rtl/brd_pkg.sv]
// Types and constants of the bounded ring deque.
package brd_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  typedef enum logic [CmdW-1:0] {
    CmdNone      = 3'd0,
    CmdPushFront = 3'd1,
    CmdPushBack  = 3'd2,
    CmdPopFront  = 3'd3,
    CmdPopBack   = 3'd4,
    CmdClear     = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StPushFull = 2'd1,
    StPopEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  front_value;
    logic [ValueW-1:0]  back_value;
    logic               empty_flag;
    logic               full_flag;
    logic [OccW-1:0]    occupancy;
  } out_beat_t;

endpackage

[rtl/brd_stream_if.sv]
// Valid/ready stream interface carrying one payload beat.
interface brd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/brd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module brd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bounded_ring_deque.sv]
// Top level of the bounded ring deque: index control, ring memories and result register.
//
// The input channel in_i carries one command beat (cmd, value_in): none, push front,
// push back, pop front, pop back or clear. Each accepted beat yields exactly one result
// beat on out_o with the status, the front and back elements after the command (zero
// when empty), the empty and full flags and the element count.
//
// A command is accepted in the idle state; the indices are updated and a push writes
// its element into the ring in that same cycle. The read state then reads the front and
// back slots from two mirrored ring memories, and the capture state registers the read
// data into the result once the result register is free. A new command is accepted
// only after the result of the previous command has been registered.
//
// The result register separates the two sides: a new command is accepted while a
// result still waits, but its own result is held back until the previous one has been
// taken, so a stalled receiver stalls the input after one further command.
//
// Reset empties the queue and drops any pending result; the ring contents are not
// cleared, as the data of an unwritten slot never reaches the result.
module bounded_ring_deque #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brd_stream_if.sink   in_i,
  brd_stream_if.source out_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCap
  } state_e;

  state_e                state_q;
  logic [IdxW-1:0]       front_q, front_d;
  logic [IdxW-1:0]       back_q, back_d;
  logic                  none_q, none_d;
  brd_pkg::status_e      status_q, status_d;
  logic                  out_valid_q;
  brd_pkg::out_beat_t    out_beat_q;

  logic                  in_fire;
  logic                  cap_fire;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [ELEM_WIDTH-1:0] front_rd, back_rd;
  logic [SumW-1:0]       span;
  logic [CntW-1:0]       count;
  logic                  full;
  logic [IdxW-1:0]       front_dn, back_up, front_up, back_dn;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cap_fire   = (state_q == StCap) && (!out_valid_q || out_o.ready);
  assign wdata      = ELEM_WIDTH'(in_i.data.value_in);

  // Element count from the two inclusive indices, wrapping round the ring.
  always_comb begin
    span = SumW'(back_q) - SumW'(front_q) + SumW'(1);
    if (front_q > back_q) begin
      span = span + SumW'(DEPTH);
    end
    count = none_q ? '0 : span[CntW-1:0];
    full  = !none_q && (count == CntW'(DEPTH));
  end

  assign front_up = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign back_up  = (back_q == IdxW'(DEPTH - 1)) ? '0 : back_q + 1'b1;
  assign front_dn = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
  assign back_dn  = (back_q == '0) ? IdxW'(DEPTH - 1) : back_q - 1'b1;

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    none_d   = none_q;
    status_d = brd_pkg::StOk;
    we       = 1'b0;
    waddr    = front_q;
    unique case (in_i.data.cmd) inside
      brd_pkg::CmdPushFront, brd_pkg::CmdPushBack: begin
        if (full) begin
          status_d = brd_pkg::StPushFull;
        end else if (none_q) begin
          // The first element always lands in slot zero, whichever end it is pushed to.
          none_d  = 1'b0;
          front_d = '0;
          back_d  = '0;
          we      = 1'b1;
          waddr   = '0;
        end else if (in_i.data.cmd == brd_pkg::CmdPushFront) begin
          front_d = front_dn;
          we      = 1'b1;
          waddr   = front_dn;
        end else begin
          back_d = back_up;
          we     = 1'b1;
          waddr  = back_up;
        end
      end
      brd_pkg::CmdPopFront, brd_pkg::CmdPopBack: begin
        if (none_q) begin
          status_d = brd_pkg::StPopEmpty;
        end else if (front_q == back_q) begin
          none_d  = 1'b1;
          front_d = '0;
          back_d  = '0;
        end else if (in_i.data.cmd == brd_pkg::CmdPopFront) begin
          front_d = front_up;
        end else begin
          back_d = back_dn;
        end
      end
      brd_pkg::CmdClear: begin
        none_d  = 1'b1;
        front_d = '0;
        back_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Both copies take every write, so each read port sees the whole ring. Writes happen
  // only on acceptance and reads only in the following cycle, so they never collide.
  brd_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (state_q == StRead),
    .raddr_i (front_q),
    .rdata_o (front_rd)
  );

  brd_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (state_q == StRead),
    .raddr_i (back_q),
    .rdata_o (back_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= '0;
      back_q      <= '0;
      none_q      <= 1'b1;
      status_q    <= brd_pkg::StOk;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
    end else begin
      if (cap_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            front_q  <= front_d;
            back_q   <= back_d;
            none_q   <= none_d;
            status_q <= status_d;
            state_q  <= StRead;
          end
        end
        StRead: begin
          state_q <= StCap;
        end
        StCap: begin
          if (cap_fire) begin
            out_beat_q.status      <= status_q;
            out_beat_q.front_value <= none_q ? '0 : brd_pkg::ValueW'(front_rd);
            out_beat_q.back_value  <= none_q ? '0 : brd_pkg::ValueW'(back_rd);
            out_beat_q.empty_flag  <= none_q;
            out_beat_q.full_flag   <= full;
            out_beat_q.occupancy   <= brd_pkg::OccW'(count);
            state_q                <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_beat_q;

endmodule

[rtl/brd_checker.sv]
// Port-level assertions for the bounded ring deque and their bind to the top level.
`include "bounded_ring_deque_macros.svh"

module brd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input brd_pkg::out_beat_t out_beat_i
);

  `BRD_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, "result beat withdrawn while stalled")

  // Commands are handled one at a time, so an accepted beat always closes the input.
  `BRD_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "input open after accept")

  `BRD_ASSERT(a_empty_result, out_valid_i && out_beat_i.empty_flag |-> out_beat_i.occupancy == '0 && out_beat_i.front_value == '0 && out_beat_i.back_value == '0 && !out_beat_i.full_flag, "empty result not cleared")

  `BRD_ASSERT(a_pop_refusal, out_valid_i && out_beat_i.status == brd_pkg::StPopEmpty |-> out_beat_i.empty_flag, "pop refused on a non-empty queue")

  `BRD_ASSERT(a_push_refusal, out_valid_i && out_beat_i.status == brd_pkg::StPushFull |-> out_beat_i.full_flag, "push refused on a queue that is not full")

endmodule

bind bounded_ring_deque brd_checker u_brd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.data)
);

[verif/bounded_ring_deque_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bounded ring deque, with its own prediction of each result.
module bounded_ring_deque_test;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned IdxW       = $clog2(DEPTH);
  localparam int unsigned CycleLimit = 200000;

  // Command codes that the block treats as no operation.
  localparam logic [brd_pkg::CmdW-1:0] CmdUnused6 = 3'd6;
  localparam logic [brd_pkg::CmdW-1:0] CmdUnused7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  brd_stream_if #(.payload_t(brd_pkg::in_beat_t))  cmd_ch ();
  brd_stream_if #(.payload_t(brd_pkg::out_beat_t)) result_ch ();

  bounded_ring_deque #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (result_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the deque, advanced once per accepted command beat.
  logic [brd_pkg::ValueW-1:0] shadow_slots [DEPTH];
  logic [IdxW-1:0]            shadow_front = '0;
  logic [IdxW-1:0]            shadow_back  = '0;
  logic                       shadow_empty = 1'b1;
  bit                         filling      = 1'b1;

  brd_pkg::out_beat_t expected_views [$];
  int unsigned        src_idle_pct  = 0;
  int unsigned        sink_idle_pct = 0;
  int unsigned        error_count   = 0;
  int unsigned        cycle_count   = 0;

  function automatic logic [brd_pkg::OccW-1:0] held_count();
    logic [IdxW-1:0] span;
    if (shadow_empty) return '0;
    span = shadow_back - shadow_front;
    return {1'b0, span} + 1'b1;
  endfunction

  function automatic void shadow_clear();
    shadow_empty = 1'b1;
    shadow_front = '0;
    shadow_back  = '0;
  endfunction

  // Applies one command to the shadow deque and returns the view the block must report.
  function automatic brd_pkg::out_beat_t deque_step(logic [brd_pkg::CmdW-1:0] c,
                                                     logic [brd_pkg::ValueW-1:0] v);
    brd_pkg::out_beat_t       view;
    brd_pkg::status_e         st;
    logic [brd_pkg::OccW-1:0] n;
    logic                     was_full;
    st       = brd_pkg::StOk;
    was_full = (held_count() == DEPTH);
    case (c)
      brd_pkg::CmdPushFront, brd_pkg::CmdPushBack: begin
        if (was_full) begin
          st = brd_pkg::StPushFull;
        end else if (shadow_empty) begin
          // The first element always lands in slot zero, whichever end it is pushed at.
          shadow_empty    = 1'b0;
          shadow_front    = '0;
          shadow_back     = '0;
          shadow_slots[0] = v;
        end else if (c == brd_pkg::CmdPushFront) begin
          shadow_front               = shadow_front - 1'b1;
          shadow_slots[shadow_front] = v;
        end else begin
          shadow_back               = shadow_back + 1'b1;
          shadow_slots[shadow_back] = v;
        end
      end
      brd_pkg::CmdPopFront, brd_pkg::CmdPopBack: begin
        if (shadow_empty) begin
          st = brd_pkg::StPopEmpty;
        end else if (shadow_front == shadow_back) begin
          shadow_clear();
        end else if (c == brd_pkg::CmdPopFront) begin
          shadow_front = shadow_front + 1'b1;
        end else begin
          shadow_back = shadow_back - 1'b1;
        end
      end
      brd_pkg::CmdClear: begin
        shadow_clear();
      end
      default: begin
      end
    endcase
    n                = held_count();
    view.status      = st;
    view.front_value = shadow_empty ? '0 : shadow_slots[shadow_front];
    view.back_value  = shadow_empty ? '0 : shadow_slots[shadow_back];
    view.empty_flag  = shadow_empty;
    view.full_flag   = (n == DEPTH);
    view.occupancy   = n;
    return view;
  endfunction

  // Offers one command beat, idling first at the sender's rate, and records its prediction.
  task automatic send_cmd(input logic [brd_pkg::CmdW-1:0] c,
                          input logic [brd_pkg::ValueW-1:0] v);
    brd_pkg::in_beat_t beat;
    beat.cmd      = c;
    beat.value_in = v;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= beat;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    expected_views.insert(expected_views.size(), deque_step(c, v));
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  // Fills towards full, then drains towards empty, with some traffic against the tide, occasional clears and no-ops.
  task automatic pick_command(output logic [brd_pkg::CmdW-1:0] c,
                              output logic [brd_pkg::ValueW-1:0] v);
    int unsigned r;
    if (held_count() == DEPTH) filling = 1'b0;
    if (shadow_empty) filling = 1'b1;
    r = $urandom_range(99);
    if (r < 2) begin
      c = brd_pkg::CmdClear;
    end else if (r < 6) begin
      case ($urandom_range(2))
        0:       c = brd_pkg::CmdNone;
        1:       c = CmdUnused6;
        default: c = CmdUnused7;
      endcase
    end else if ((r < 76) == filling) begin
      c = $urandom_range(1) ? brd_pkg::CmdPushFront : brd_pkg::CmdPushBack;
    end else begin
      c = $urandom_range(1) ? brd_pkg::CmdPopFront : brd_pkg::CmdPopBack;
    end
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
  endtask

  task automatic run_corner_cases();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_cmd(brd_pkg::CmdPopFront, 32'h1234_5678);
    send_cmd(brd_pkg::CmdPopBack, 32'h8765_4321);
    send_cmd(brd_pkg::CmdNone, 32'hDEAD_BEEF);
    send_cmd(brd_pkg::CmdPushFront, 32'h0000_0000);
    send_cmd(brd_pkg::CmdPopBack, 32'h0);
    send_cmd(brd_pkg::CmdPushBack, 32'hFFFF_FFFF);
    for (int unsigned i = 1; i < DEPTH; i++) begin
      send_cmd((i % 2) ? brd_pkg::CmdPushFront : brd_pkg::CmdPushBack,
               (i % 2) ? 32'hA5A5_0000 | i : 32'h5A5A_0000 | i);
    end
    send_cmd(brd_pkg::CmdPushFront, 32'h1111_1111);
    send_cmd(brd_pkg::CmdPushBack, 32'h2222_2222);
    send_cmd(CmdUnused6, 32'h3333_3333);
    send_cmd(CmdUnused7, 32'h4444_4444);
    send_cmd(brd_pkg::CmdClear, 32'h5555_5555);
    send_cmd(brd_pkg::CmdPopFront, 32'h0);
    wait_for_results();
  endtask

  task automatic run_random_traffic(input int unsigned beats, input int unsigned src_pct,
                                    input int unsigned sink_pct);
    logic [brd_pkg::CmdW-1:0]   c;
    logic [brd_pkg::ValueW-1:0] v;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i == beats / 2) wait_for_results();
      pick_command(c, v);
      send_cmd(c, v);
    end
    wait_for_results();
  endtask

  task automatic check_field(input string name, input logic [brd_pkg::ValueW-1:0] want,
                             input logic [brd_pkg::ValueW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : compare_results
    brd_pkg::out_beat_t want;
    brd_pkg::out_beat_t got;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_views.size() == 0) begin
        $display("%0t: result beat with no command outstanding, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_views[0];
        expected_views.delete(0);
        check_field("status", brd_pkg::ValueW'(want.status),
                    brd_pkg::ValueW'(got.status));
        check_field("front_value", want.front_value, got.front_value);
        check_field("back_value", want.back_value, got.back_value);
        check_field("empty_flag", brd_pkg::ValueW'(want.empty_flag),
                    brd_pkg::ValueW'(got.empty_flag));
        check_field("full_flag", brd_pkg::ValueW'(want.full_flag),
                    brd_pkg::ValueW'(got.full_flag));
        check_field("occupancy", brd_pkg::ValueW'(want.occupancy),
                    brd_pkg::ValueW'(got.occupancy));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_corner_cases();
    run_random_traffic(150, 17, 86);
    run_random_traffic(150, 86, 17);
    run_random_traffic(150, 0, 0);
    // Give any stray result beat time to show up.
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/brd_pkg.sv
rtl/brd_stream_if.sv
rtl/brd_ram.sv
rtl/bounded_ring_deque.sv
rtl/brd_checker.sv
verif/bounded_ring_deque_test.sv
